### hdl/bilinear_height_sampler_defines.svh
// Assertion helpers shared by the block.
`ifndef BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH
`define BILINEAR_HEIGHT_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BHS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bhs: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bhs: next-cycle check failed");

`endif

### hdl/bhs_pkg.sv
package bhs_pkg;

	localparam int SIDE_DEF      = 256;
	localparam int FRAC_BITS_DEF = 8;

	localparam logic [8:0] SIDE_RESET = 9'd256;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} bhs_state_t;

endpackage

### hdl/bhs_req_if.sv
interface bhs_req_if;
	logic               valid;
	logic               ready;
	logic               req_type;
	logic [7:0]         pixel_col;
	logic [7:0]         pixel_row;
	logic signed [15:0] pixel_value;
	logic [15:0]        point_x;
	logic [15:0]        point_y;

	modport source (
		output valid, req_type, pixel_col, pixel_row, pixel_value, point_x, point_y,
		input  ready
	);
	modport sink (
		input  valid, req_type, pixel_col, pixel_row, pixel_value, point_x, point_y,
		output ready
	);
endinterface

### hdl/bhs_smp_if.sv
interface bhs_smp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_value;

	modport source (
		output valid, sample_value,
		input  ready
	);
	modport sink (
		input  valid, sample_value,
		output ready
	);
endinterface

### hdl/bilinear_height_sampler.sv
// Height image store with clamp-to-edge bilinear sampling. A write request
// stores one pixel in ST_WRITE, and ready returns once it is back in ST_IDLE.
// A sample request is accepted and its point clamped in ST_IDLE; ST_READ then
// reads the four neighbours through the single port of the pixel RAM, three
// lerps run on one shared multiplier (ST_MUL, then ST_ADD), and ST_DONE loads
// the output register; ready then returns once that register is free. The
// store has no reset and no clearing pass; only written pixels may be read.
// The user must write side_q via cfg_we/cfg_wdata only while idle; unenforced.
module bilinear_height_sampler
	import bhs_pkg::*;
#(
	parameter int SIDE      = SIDE_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [8:0]    cfg_wdata,
	bhs_req_if.sink       req,
	bhs_smp_if.source     smp
);

	`include "bilinear_height_sampler_defines.svh"

	localparam int CW = $clog2(SIDE);
	localparam int AW = 2 * CW;
	localparam int DEPTH = 1 << AW;
	localparam int IW = 17 - FRAC_BITS;
	localparam int KA = (CW + 1 > IW) ? CW + 1 : IW;
	localparam int KW = (KA > 10) ? KA : 10;
	localparam int PW = 18 + FRAC_BITS;

	bhs_state_t state_q, state_d;

	logic [8:0]           side_q;
	logic                 type_q;
	logic                 wr_ok_q;
	logic signed [15:0]   val_q;
	logic [CW-1:0]        c0_q, c1_q, r0_q, r1_q;
	logic [FRAC_BITS-1:0] tx_q, ty_q;
	logic [1:0]           rd_cnt_q;
	logic                 rd_vld_s1;
	logic [1:0]           rd_idx_s1;
	logic signed [15:0]   pix_q [4];
	logic [1:0]           lp_q;
	logic signed [PW-1:0] prod_q;
	logic signed [15:0]   a_q;
	logic signed [15:0]   top_q, bot_q, res_q;
	logic                 smp_valid_q;
	logic signed [15:0]   smp_value_q;

	// point clamp
	logic [KW-1:0] side_k, eff_side, lim;
	logic [KW-1:0] px_int, py_int, c0, r0, c1, r1;
	logic [KW-1:0] wcol, wrow;
	logic          wr_ok;
	logic          req_acc;

	assign req_acc = req.valid && req.ready;
	assign side_k  = KW'(side_q);

	always_comb begin
		if (side_q == 9'd0) begin
			eff_side = KW'(1);
		end else if (side_k > KW'(SIDE)) begin
			eff_side = KW'(SIDE);
		end else begin
			eff_side = side_k;
		end
		lim    = eff_side - KW'(1);
		px_int = KW'({1'b0, req.point_x} >> FRAC_BITS);
		py_int = KW'({1'b0, req.point_y} >> FRAC_BITS);
		c0     = (px_int > lim) ? lim : px_int;
		r0     = (py_int > lim) ? lim : py_int;
		c1     = (c0 == lim) ? lim : c0 + KW'(1);
		r1     = (r0 == lim) ? lim : r0 + KW'(1);
		wcol   = KW'(req.pixel_col);
		wrow   = KW'(req.pixel_row);
		wr_ok  = (wcol < KW'(SIDE)) && (wrow < KW'(SIDE));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
		end else if (cfg_we) begin
			side_q <= cfg_wdata;
		end
	end

	// request capture; a write reuses c0/r0 for its coordinates
	always_ff @(posedge clk) begin
		if (req_acc) begin
			type_q  <= req.req_type;
			wr_ok_q <= wr_ok;
			val_q   <= req.pixel_value;
			tx_q    <= req.point_x[FRAC_BITS-1:0];
			ty_q    <= req.point_y[FRAC_BITS-1:0];
			c1_q    <= c1[CW-1:0];
			r1_q    <= r1[CW-1:0];
			if (req.req_type == REQ_WRITE) begin
				c0_q <= wcol[CW-1:0];
				r0_q <= wrow[CW-1:0];
			end else begin
				c0_q <= c0[CW-1:0];
				r0_q <= r0[CW-1:0];
			end
		end
	end

	// pixel RAM
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_rdata;
	logic [CW-1:0] rd_col, rd_row;

	assign rd_col   = rd_cnt_q[0] ? c1_q : c0_q;
	assign rd_row   = rd_cnt_q[1] ? r1_q : r0_q;
	assign ram_we   = (state_q == ST_WRITE) && wr_ok_q;
	assign ram_addr = (state_q == ST_WRITE) ? {r0_q, c0_q} : {rd_row, rd_col};

	bhs_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(val_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= (state_q == ST_READ);
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_cnt_q;
		if (rd_vld_s1) begin
			pix_q[rd_idx_s1] <= ram_rdata;
		end
	end

	// shared lerp unit: a + ((b - a) * t) >>> FRAC_BITS, floor rounding
	logic signed [15:0]        a_sel, b_sel;
	logic [FRAC_BITS-1:0]      t_sel;
	logic signed [16:0]        diff;
	logic signed [FRAC_BITS:0] t_s;
	logic signed [PW-1:0]      prod, prod_sh;
	logic signed [15:0]        lerp_res;

	always_comb begin
		case (lp_q)
			2'd0: begin
				a_sel = pix_q[0];
				b_sel = pix_q[1];
				t_sel = tx_q;
			end
			2'd1: begin
				a_sel = pix_q[2];
				b_sel = pix_q[3];
				t_sel = tx_q;
			end
			default: begin
				a_sel = top_q;
				b_sel = bot_q;
				t_sel = ty_q;
			end
		endcase
		diff     = {b_sel[15], b_sel} - {a_sel[15], a_sel};
		t_s      = {1'b0, t_sel};
		prod     = PW'(diff) * PW'(t_s);
		prod_sh  = prod_q >>> FRAC_BITS;
		lerp_res = a_q + prod_sh[15:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= prod;
			a_q    <= a_sel;
		end
		if (state_q == ST_ADD) begin
			case (lp_q)
				2'd0:    top_q <= lerp_res;
				2'd1:    bot_q <= lerp_res;
				default: res_q <= lerp_res;
			endcase
		end
	end

	// sequencer
	logic out_load;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = (req.req_type == REQ_WRITE) ? ST_WRITE : ST_READ;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_READ: begin
				if (rd_cnt_q == 2'd3) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_ADD;
			ST_ADD: state_d = (lp_q == 2'd2) ? ST_DONE : ST_MUL;
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		out_load  = (state_q == ST_DONE) && (!smp_valid_q || smp.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_cnt_q    <= 2'd0;
			lp_q        <= 2'd0;
			smp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_READ) begin
				rd_cnt_q <= rd_cnt_q + 2'd1;
			end else begin
				rd_cnt_q <= 2'd0;
			end
			if (state_q == ST_ADD) begin
				lp_q <= lp_q + 2'd1;
			end else if (state_q == ST_IDLE) begin
				lp_q <= 2'd0;
			end
			if (out_load) begin
				smp_valid_q <= 1'b1;
			end else if (smp.ready) begin
				smp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			smp_value_q <= res_q;
		end
	end

	assign smp.valid        = smp_valid_q;
	assign smp.sample_value = smp_value_q;

	`BHS_ASSERT_NEXT(a_sample_reads, clk, arst_n, req_acc && req.req_type == REQ_SAMPLE, state_q == ST_READ)
	`BHS_ASSERT_NEXT(a_read_done, clk, arst_n, state_q == ST_READ && rd_cnt_q == 2'd3, state_q == ST_MUL && lp_q == 2'd0)
	`BHS_ASSERT_IMPL(a_rd_return, clk, arst_n, rd_vld_s1, state_q == ST_READ || (state_q == ST_MUL && lp_q == 2'd0))
	`BHS_ASSERT_NEXT(a_out_load, clk, arst_n, out_load, smp.valid && state_q == ST_IDLE && type_q == REQ_SAMPLE)

endmodule

### hdl/bhs_ram.sv
module bhs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### sim/tb_top.sv
module tb_top;
	import bhs_pkg::*;

	localparam int SIDE = SIDE_DEF;
	localparam int FRAC = FRAC_BITS_DEF;
	localparam int FMASK = (1 << FRAC) - 1;

	typedef struct {
		logic               kind;
		logic [7:0]         col;
		logic [7:0]         row;
		logic signed [15:0] value;
		logic [15:0]        px;
		logic [15:0]        py;
		bit                 drain_first;
	} height_req_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [8:0] cfg_wdata;

	bhs_req_if req ();
	bhs_smp_if smp ();

	bilinear_height_sampler uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.smp       (smp)
	);

	height_req_t        height_reqs[$];
	height_req_t        cur_req;
	logic signed [15:0] expected_heights[$];
	logic signed [15:0] want_height;
	logic signed [15:0] height_mem [0:SIDE*SIDE-1];
	bit                 written_map [0:SIDE*SIDE-1];
	logic [8:0]         side_shadow;
	int                 gen_side;
	int                 pushed;
	int                 src_gap;
	int                 snk_gap;
	int                 mismatches;
	bit                 req_taken;
	bit                 calm;
	bit                 drain_next;

	function automatic int clamp_side(int s);
		if (s == 0)
			return 1;
		if (s > SIDE)
			return SIDE;
		return s;
	endfunction

	// floor rounding: arithmetic shift of a signed product
	function automatic int lerp_floor(int a, int b, int t);
		longint d;
		d = longint'(b - a) * longint'(t);
		return a + int'(d >>> FRAC);
	endfunction

	function automatic logic signed [15:0] predict_height(logic [15:0] px, logic [15:0] py);
		int lim, c0, r0, c1, r1, tx, ty, top, bot, res;
		lim = clamp_side(int'(side_shadow)) - 1;
		c0 = int'(px) >> FRAC;
		r0 = int'(py) >> FRAC;
		tx = int'(px) & FMASK;
		ty = int'(py) & FMASK;
		if (c0 > lim)
			c0 = lim;
		if (r0 > lim)
			r0 = lim;
		c1 = (c0 + 1 > lim) ? lim : c0 + 1;
		r1 = (r0 + 1 > lim) ? lim : r0 + 1;
		top = lerp_floor(height_mem[r0*SIDE + c0], height_mem[r0*SIDE + c1], tx);
		bot = lerp_floor(height_mem[r1*SIDE + c0], height_mem[r1*SIDE + c1], tx);
		res = lerp_floor(top, bot, ty);
		return res[15:0];
	endfunction

	// ---------------- stimulus generation ----------------

	function automatic logic signed [15:0] random_height();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [15:0] pick_coord();
		case ($urandom_range(0, 7))
			0, 1: return 16'($urandom);
			2: return 16'(((gen_side - 1) << FRAC) | $urandom_range(0, FMASK));
			3: return 16'(($urandom_range(0, gen_side - 1) << FRAC) |
					($urandom_range(0, 1) ? 0 : FMASK));
			default: return 16'($urandom_range(0, (gen_side << FRAC) - 1));
		endcase
	endfunction

	task automatic push_req(height_req_t r);
		r.drain_first = drain_next;
		drain_next = 0;
		height_reqs.push_back(r);
		pushed++;
	endtask

	task automatic push_write(int col, int row, logic signed [15:0] value);
		height_req_t r;
		r.kind = REQ_WRITE;
		r.col = 8'(col);
		r.row = 8'(row);
		r.value = value;
		r.px = 16'($urandom);
		r.py = 16'($urandom);
		written_map[row*SIDE + col] = 1'b1;
		push_req(r);
	endtask

	// fills any neighbour not yet written before issuing the sample
	task automatic push_sample(logic [15:0] px, logic [15:0] py);
		height_req_t r;
		int lim, c0, r0, c1, r1;
		lim = gen_side - 1;
		c0 = int'(px) >> FRAC;
		r0 = int'(py) >> FRAC;
		if (c0 > lim)
			c0 = lim;
		if (r0 > lim)
			r0 = lim;
		c1 = (c0 + 1 > lim) ? lim : c0 + 1;
		r1 = (r0 + 1 > lim) ? lim : r0 + 1;
		if (!written_map[r0*SIDE + c0] || $urandom_range(0, 7) == 0)
			push_write(c0, r0, random_height());
		if (!written_map[r0*SIDE + c1] || $urandom_range(0, 7) == 0)
			push_write(c1, r0, random_height());
		if (!written_map[r1*SIDE + c0] || $urandom_range(0, 7) == 0)
			push_write(c0, r1, random_height());
		if (!written_map[r1*SIDE + c1] || $urandom_range(0, 7) == 0)
			push_write(c1, r1, random_height());
		r.kind = REQ_SAMPLE;
		r.col = 8'($urandom);
		r.row = 8'($urandom);
		r.value = 16'($urandom);
		r.px = px;
		r.py = py;
		push_req(r);
	endtask

	task automatic settle();
		while (height_reqs.size() != 0 || req.valid || expected_heights.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_side(int v);
		settle();
		// a write request may still be in flight with nothing to wait on
		repeat (16) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 9'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		gen_side = clamp_side(v);
	endtask

	task automatic run_phase(int side, int n);
		int stop;
		set_side(side);
		stop = pushed + n;
		while (pushed < stop) begin
			if ($urandom_range(0, 149) == 0)
				drain_next = 1;
			if ($urandom_range(0, 4) == 0)
				push_write($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
					random_height());
			else
				push_sample(pick_coord(), pick_coord());
		end
	endtask

	// ---------------- clock, reset, sequence ----------------

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req.valid = 1'b0;
		req.req_type = REQ_WRITE;
		req.pixel_col = '0;
		req.pixel_row = '0;
		req.pixel_value = '0;
		req.point_x = '0;
		req.point_y = '0;
		smp.ready = 1'b1;
		gen_side = SIDE;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// opposite extremes at the corner, then fraction 0, half and max
		push_write(0, 0, 16'sh8000);
		push_write(1, 0, 16'sh7fff);
		push_write(0, 1, 16'sh7fff);
		push_write(1, 1, 16'sh8000);
		push_sample(16'h0000, 16'h0000);
		push_sample(16'h0080, 16'h0080);
		push_sample(16'h00ff, 16'h00ff);
		push_sample(16'h00ff, 16'h0000);
		// far corner: edge pixel blended with itself
		push_write(255, 255, 16'sh7fff);
		push_write(254, 255, 16'sh8000);
		push_write(255, 254, 16'sh0001);
		push_write(254, 254, 16'shffff);
		push_sample(16'hffff, 16'hffff);
		push_sample(16'hfeff, 16'hfeff);
		push_sample(16'hfe80, 16'hffff);
		drain_next = 1;
		push_sample(16'h0000, 16'hffff);

		run_phase(256, 330);
		run_phase(1, 70);
		run_phase(0, 60);
		run_phase(2, 80);
		run_phase(511, 120);
		run_phase(3, 70);
		run_phase(300, 60);
		run_phase($urandom_range(4, 255), 120);
		run_phase(17, 70);
		calm = 1;
		run_phase(256, 200);

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_heights.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#3000000;
		$display("== FAIL ==");
		$finish;
	end

	// ---------------- driver ----------------

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken && !calm && $urandom_range(0, 4) == 0)
				src_gap = $urandom_range(1, 4);
			if (req_taken || !req.valid) begin
				if (src_gap > 0) begin
					src_gap--;
					req.valid <= 1'b0;
				end else if (height_reqs.size() != 0 &&
						!(height_reqs[0].drain_first && expected_heights.size() != 0)) begin
					cur_req = height_reqs.pop_front();
					req.valid <= 1'b1;
					req.req_type <= cur_req.kind;
					req.pixel_col <= cur_req.col;
					req.pixel_row <= cur_req.row;
					req.pixel_value <= cur_req.value;
					req.point_x <= cur_req.px;
					req.point_y <= cur_req.py;
				end else begin
					req.valid <= 1'b0;
				end
			end
			if (snk_gap > 0) begin
				snk_gap--;
				smp.ready <= 1'b0;
			end else begin
				smp.ready <= 1'b1;
				if (!calm && $urandom_range(0, 5) == 0)
					snk_gap = $urandom_range(1, 4);
			end
		end
	end

	// ---------------- predictor and checker ----------------

	always @(posedge clk) begin
		req_taken = arst_n && req.valid && req.ready;
		if (!arst_n) begin
			side_shadow = SIDE_RESET;
		end else begin
			if (cfg_we)
				side_shadow = cfg_wdata;
			if (smp.valid && smp.ready) begin
				if (expected_heights.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected sample result %0d", $time,
							smp.sample_value);
				end else begin
					want_height = expected_heights.pop_front();
					if (smp.sample_value !== want_height) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: sample_value expected %0d got %0d", $time,
								want_height, smp.sample_value);
					end
				end
			end
			if (req_taken) begin
				if (cur_req.kind == REQ_WRITE)
					height_mem[int'(cur_req.row)*SIDE + int'(cur_req.col)] = cur_req.value;
				else
					expected_heights.push_back(predict_height(cur_req.px, cur_req.py));
			end
		end
	end

endmodule
